/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the money flow index RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* hdl/mfi_pkg.sv */
// ---------------------------------------------------------------------------
// mfi_pkg
// Shared constants, codes and types of the money flow index block.
// ---------------------------------------------------------------------------
`default_nettype none

package mfi_pkg;

   // field widths of the channels
   localparam int PRICE_W     = 20;
   localparam int PRICE_EXT_W = 24;
   localparam int VOLUME_W    = 32;
   localparam int PERIOD_W    = 9;
   localparam int MFI_W       = 15;
   localparam int COUNT_W     = 9;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd14;

   // index scaling: percent times 256
   localparam logic [MFI_W-1:0] MFI_SCALE = 15'd25600;
   localparam logic [MFI_W-1:0] MFI_HALF  = 15'd12800;

   // one quotient bit per divider step
   localparam int DIV_STEPS = 15;

   // flow class codes stored with each ring entry
   localparam logic [1:0] CLS_NONE = 2'd0;
   localparam logic [1:0] CLS_POS  = 2'd1;
   localparam logic [1:0] CLS_NEG  = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

/* hdl/mfi_req_if.sv */
// ---------------------------------------------------------------------------
// mfi_req_if
// Price bar channel: valid/ready handshake with one bar per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface mfi_req_if import mfi_pkg::*;;
   logic                valid;
   logic                ready;
   logic                restart;
   logic [PRICE_W-1:0]  high_price;
   logic [PRICE_W-1:0]  low_price;
   logic [PRICE_W-1:0]  close_price;
   logic [VOLUME_W-1:0] bar_volume;

   modport source (
      output valid, restart, high_price, low_price, close_price, bar_volume,
      input  ready
   );
   modport sink (
      input  valid, restart, high_price, low_price, close_price, bar_volume,
      output ready
   );
endinterface

`default_nettype wire

/* hdl/mfi_rsp_if.sv */
// ---------------------------------------------------------------------------
// mfi_rsp_if
// Result channel: valid/ready handshake with one index value per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface mfi_rsp_if import mfi_pkg::*;;
   logic               valid;
   logic               ready;
   logic [MFI_W-1:0]   mfi_value;
   logic [COUNT_W-1:0] flows_in_window;

   modport source (output valid, mfi_value, flows_in_window, input ready);
   modport sink   (input  valid, mfi_value, flows_in_window, output ready);
endinterface

`default_nettype wire

/* hdl/mfi_ram.sv */
// ---------------------------------------------------------------------------
// mfi_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mfi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/mfi_div.sv */
// ---------------------------------------------------------------------------
// mfi_div
// Scales the positive sum by 25600 and divides by the window total, one
// quotient bit per cycle, then rounds half up.
// ---------------------------------------------------------------------------
`default_nettype none

module mfi_div import mfi_pkg::*; #(
   parameter int SUM_W = 62
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] pos_sum,
   input  wire logic [SUM_W-1:0] neg_sum,
   output logic      [MFI_W-1:0] quotient,
   output div_status_type        status
);

   localparam int NUM_W = SUM_W + 5;           // 25 * pos
   localparam int REM_W = SUM_W + 1;           // total width
   localparam int CNT_W = $clog2(DIV_STEPS);

   localparam logic [2:0] D_IDLE  = 3'd0;
   localparam logic [2:0] D_SCALE = 3'd1;
   localparam logic [2:0] D_INIT  = 3'd2;
   localparam logic [2:0] D_STEP  = 3'd3;
   localparam logic [2:0] D_ROUND = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [SUM_W-1:0]     pos_ff, pos_in;
   logic [REM_W-1:0]     total_ff, total_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DIV_STEPS-1:0] low_ff, low_in;
   logic [MFI_W-1:0]     q_ff, q_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [MFI_W-1:0]     quot_ff, quot_in;
   logic                 done_ff, done_in;

   logic [REM_W:0]       trial;
   logic                 fits;
   logic                 round_up;
   logic [MFI_W:0]       q_round;

   // numerator is 25 * pos shifted left by 10; shift in its low bits
   assign trial    = {rem_ff, low_ff[DIV_STEPS-1]};
   assign fits     = trial >= {1'b0, total_ff};
   assign round_up = {rem_ff, 1'b0} >= {1'b0, total_ff};
   assign q_round  = {1'b0, q_ff} + (MFI_W+1)'(round_up);

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      total_in = total_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      quot_in  = quot_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               pos_in   = pos_sum;
               total_in = REM_W'(pos_sum) + REM_W'(neg_sum);
               num_in   = NUM_W'(pos_sum) + (NUM_W'(pos_sum) << 3);
               state_in = D_SCALE;
            end
         end
         D_SCALE: begin
            num_in   = num_ff + (NUM_W'(pos_ff) << 4);
            state_in = D_INIT;
         end
         D_INIT: begin
            rem_in   = REM_W'(num_ff[NUM_W-1:5]);
            low_in   = {num_ff[4:0], 10'd0};
            q_in     = '0;
            cnt_in   = CNT_W'(DIV_STEPS - 1);
            state_in = D_STEP;
         end
         D_STEP: begin
            rem_in = fits ? REM_W'(trial - {1'b0, total_ff}) : REM_W'(trial);
            q_in   = {q_ff[MFI_W-2:0], fits};
            low_in = low_ff << 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = D_ROUND;
            end
         end
         D_ROUND: begin
            quot_in  = (q_round > {1'b0, MFI_SCALE}) ? MFI_SCALE : q_round[MFI_W-1:0];
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      pos_ff   <= pos_in;
      total_ff <= total_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      quot_ff  <= quot_in;
   end

   assign quotient    = quot_ff;
   assign status.busy = (state_ff != D_IDLE);
   assign status.done = done_ff;

endmodule

`default_nettype wire

/* hdl/money_flow_index_top.sv */
// ---------------------------------------------------------------------------
// money_flow_index_top
// Money Flow Index over a sliding window of price bars.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one price bar per transfer (restart, high, low, close,
//   volume); rsp_chan returns one result per bar: the index in percent
//   scaled by 256 and the number of bar-to-bar flows it covers.
//   csr_wr_en/csr_wr_data write the window period; write it only while no
//   bar is in flight. Zero acts as one, values above MAX_PERIOD as
//   MAX_PERIOD, and a new period takes effect at the next bar.
// Sequence:
//   The block works through one bar at a time. A restart bar (or the first
//   bar after reset) goes from SUM and MUL straight to OUT. Any other bar
//   reads, modifies and writes the flow ring, each read taking an ADJ/UPD
//   state pair, and runs the 15-step serial divider when the negative sum
//   is not zero. Each flow entered into or dropped from the window beyond
//   the usual one adds an ADJ/UPD pair, so a period change lengthens the
//   next bar by one pair for each flow the window gains or loses.
// Reset: synchronous, active high. Clears the history and sets the period
//   to 14; the ring needs no clearing pass, since only written entries are read.
// Stalls: the result register holds a finished result until rsp_chan takes
//   it; the next bar is taken and worked on meanwhile and waits only for the
//   register to free up.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module money_flow_index_top import mfi_pkg::*; #(
   parameter int MAX_PERIOD = 256,
   parameter int PRICE_BITS = 20
) (
   input  wire logic                clock,
   input  wire logic                reset,
   mfi_req_if.sink                  req_chan,
   mfi_rsp_if.source                rsp_chan,
   input  wire logic                csr_wr_en,
   input  wire logic [PERIOD_W-1:0] csr_wr_data
);

   localparam int TP_W    = PRICE_BITS + 2;
   localparam int FLOW_W  = TP_W + VOLUME_W;
   localparam int ENTRY_W = FLOW_W + 2;
   localparam int SUM_W   = FLOW_W + $clog2(MAX_PERIOD);
   localparam int PTR_W   = $clog2(MAX_PERIOD);
   localparam int CNT_W   = $clog2(MAX_PERIOD + 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SUM   = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_ADJ   = 4'd3;
   localparam logic [3:0] ST_UPD   = 4'd4;
   localparam logic [3:0] ST_WR    = 4'd5;
   localparam logic [3:0] ST_RATIO = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PERIOD);

   // control and history
   logic [3:0]          state_ff, state_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic                seen_ff, seen_in;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    held_ff, held_in;
   logic [CNT_W-1:0]    win_ff, win_in;
   logic [CNT_W-1:0]    tgt_ff, tgt_in;
   logic                phase_ff, phase_in;
   logic                shrink_ff, shrink_in;
   logic [TP_W-1:0]     prev_ff, prev_in;
   logic [SUM_W-1:0]    pos_ff, pos_in;
   logic [SUM_W-1:0]    neg_ff, neg_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // bar payload and results
   logic                restart_ff, restart_in;
   logic [PRICE_W-1:0]  high_ff, high_in;
   logic [PRICE_W-1:0]  low_ff, low_in;
   logic [PRICE_W-1:0]  close_ff, close_in;
   logic [VOLUME_W-1:0] vol_ff, vol_in;
   logic [TP_W-1:0]     tp_ff, tp_in;
   logic [FLOW_W-1:0]   flow_ff, flow_in;
   logic [1:0]          cls_ff, cls_in;
   logic [MFI_W-1:0]    res_mfi_ff, res_mfi_in;
   logic [COUNT_W-1:0]  res_n_ff, res_n_in;
   logic [MFI_W-1:0]    rsp_mfi_ff, rsp_mfi_in;
   logic [COUNT_W-1:0]  rsp_n_ff, rsp_n_in;

   // ring access
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [PTR_W-1:0]    ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;
   logic [FLOW_W-1:0]   ent_flow;
   logic [1:0]          ent_cls;

   // window helpers
   logic [PRICE_EXT_W-1:0] high_ext, low_ext, close_ext;
   logic [CNT_W-1:0]    period_clamp;
   logic [CNT_W-1:0]    held_next;
   logic [CNT_W-1:0]    win_sel;
   logic [CNT_W:0]      idx_wide;
   logic [PTR_W-1:0]    ptr_next;

   // divider
   logic                div_start;
   logic [MFI_W-1:0]    div_quot;
   div_status_type      div_stat;

   assign high_ext  = PRICE_EXT_W'(high_ff);
   assign low_ext   = PRICE_EXT_W'(low_ff);
   assign close_ext = PRICE_EXT_W'(close_ff);

   assign period_clamp = (period_ff == '0)              ? CNT_W'(1) :
                         (int'(period_ff) > MAX_PERIOD) ? MAX_CNT   : CNT_W'(period_ff);
   assign held_next    = (held_ff == MAX_CNT) ? held_ff : held_ff + CNT_W'(1);
   assign ptr_next     = (ptr_ff == PTR_W'(MAX_PERIOD - 1)) ? '0 : ptr_ff + PTR_W'(1);

   // oldest entry on a drop, next older entry on a grow
   assign win_sel  = (win_ff > tgt_ff) ? win_ff : win_ff + CNT_W'(1);
   assign idx_wide = (CNT_W+1)'(ptr_ff) + (CNT_W+1)'(MAX_PERIOD) - (CNT_W+1)'(win_sel);
   assign ram_rd_addr = (idx_wide >= (CNT_W+1)'(MAX_PERIOD)) ?
                        PTR_W'(idx_wide - (CNT_W+1)'(MAX_PERIOD)) : PTR_W'(idx_wide);

   assign ent_flow = ram_rd_data[ENTRY_W-1:2];
   assign ent_cls  = ram_rd_data[1:0];

   assign ram_rd_en = (state_ff == ST_ADJ) && (win_ff != tgt_ff);
   assign ram_wr_en = (state_ff == ST_WR);

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      period_in    = csr_wr_en ? csr_wr_data : period_ff;
      seen_in      = seen_ff;
      ptr_in       = ptr_ff;
      held_in      = held_ff;
      win_in       = win_ff;
      tgt_in       = tgt_ff;
      phase_in     = phase_ff;
      shrink_in    = shrink_ff;
      prev_in      = prev_ff;
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      restart_in   = restart_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      close_in     = close_ff;
      vol_in       = vol_ff;
      tp_in        = tp_ff;
      flow_in      = flow_ff;
      cls_in       = cls_ff;
      res_mfi_in   = res_mfi_ff;
      res_n_in     = res_n_ff;
      rsp_mfi_in   = rsp_mfi_ff;
      rsp_n_in     = rsp_n_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               restart_in = req_chan.restart;
               high_in    = req_chan.high_price;
               low_in     = req_chan.low_price;
               close_in   = req_chan.close_price;
               vol_in     = req_chan.bar_volume;
               state_in   = ST_SUM;
            end
         end
         ST_SUM: begin
            tp_in    = TP_W'(high_ext[PRICE_BITS-1:0]) + TP_W'(low_ext[PRICE_BITS-1:0])
                     + TP_W'(close_ext[PRICE_BITS-1:0]);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prev_in = tp_ff;
            if (restart_ff || !seen_ff) begin
               // first bar of a series: drop all history
               seen_in    = 1'b1;
               ptr_in     = '0;
               held_in    = '0;
               win_in     = '0;
               pos_in     = '0;
               neg_in     = '0;
               res_mfi_in = MFI_HALF;
               res_n_in   = '0;
               state_in   = ST_OUT;
            end else begin
               flow_in = tp_ff * vol_ff;
               priority if (tp_ff > prev_ff) begin
                  cls_in = CLS_POS;
               end else if (tp_ff < prev_ff) begin
                  cls_in = CLS_NEG;
               end else begin
                  cls_in = CLS_NONE;
               end
               // a full window must first drop the slot about to be overwritten
               tgt_in   = (win_ff == MAX_CNT) ? MAX_CNT - CNT_W'(1) : win_ff;
               phase_in = 1'b0;
               state_in = ST_ADJ;
            end
         end
         ST_ADJ: begin
            if (win_ff == tgt_ff) begin
               state_in = phase_ff ? ST_RATIO : ST_WR;
            end else begin
               shrink_in = (win_ff > tgt_ff);
               state_in  = ST_UPD;
            end
         end
         ST_UPD: begin
            if (ent_cls == CLS_POS) begin
               pos_in = shrink_ff ? pos_ff - SUM_W'(ent_flow) : pos_ff + SUM_W'(ent_flow);
            end
            if (ent_cls == CLS_NEG) begin
               neg_in = shrink_ff ? neg_ff - SUM_W'(ent_flow) : neg_ff + SUM_W'(ent_flow);
            end
            win_in   = shrink_ff ? win_ff - CNT_W'(1) : win_ff + CNT_W'(1);
            state_in = ST_ADJ;
         end
         ST_WR: begin
            if (cls_ff == CLS_POS) begin
               pos_in = pos_ff + SUM_W'(flow_ff);
            end
            if (cls_ff == CLS_NEG) begin
               neg_in = neg_ff + SUM_W'(flow_ff);
            end
            ptr_in   = ptr_next;
            held_in  = held_next;
            win_in   = win_ff + CNT_W'(1);
            tgt_in   = (held_next < period_clamp) ? held_next : period_clamp;
            phase_in = 1'b1;
            state_in = ST_ADJ;
         end
         ST_RATIO: begin
            res_n_in = COUNT_W'(win_ff);
            priority if (pos_ff == '0 && neg_ff == '0) begin
               res_mfi_in = MFI_HALF;
               state_in   = ST_OUT;
            end else if (neg_ff == '0) begin
               res_mfi_in = MFI_SCALE;
               state_in   = ST_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               res_mfi_in = div_quot;
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            // hand over once the result register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_mfi_in   = res_mfi_ff;
               rsp_n_in     = res_n_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_RESET;
         seen_ff      <= 1'b0;
         ptr_ff       <= '0;
         held_ff      <= '0;
         win_ff       <= '0;
         tgt_ff       <= '0;
         phase_ff     <= 1'b0;
         shrink_ff    <= 1'b0;
         prev_ff      <= '0;
         pos_ff       <= '0;
         neg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         seen_ff      <= seen_in;
         ptr_ff       <= ptr_in;
         held_ff      <= held_in;
         win_ff       <= win_in;
         tgt_ff       <= tgt_in;
         phase_ff     <= phase_in;
         shrink_ff    <= shrink_in;
         prev_ff      <= prev_in;
         pos_ff       <= pos_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      restart_ff <= restart_in;
      high_ff    <= high_in;
      low_ff     <= low_in;
      close_ff   <= close_in;
      vol_ff     <= vol_in;
      tp_ff      <= tp_in;
      flow_ff    <= flow_in;
      cls_ff     <= cls_in;
      res_mfi_ff <= res_mfi_in;
      res_n_ff   <= res_n_in;
      rsp_mfi_ff <= rsp_mfi_in;
      rsp_n_ff   <= rsp_n_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.mfi_value       = rsp_mfi_ff;
   assign rsp_chan.flows_in_window = rsp_n_ff;

   mfi_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_PERIOD)
   ) u_flow_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_ff),
      .wr_data ({flow_ff, cls_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mfi_div #(
      .SUM_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .pos_sum  (pos_ff),
      .neg_sum  (neg_ff),
      .quotient (div_quot),
      .status   (div_stat)
   );

   `ASSERT_ALWAYS(a_win_le_held, clock, reset, win_ff <= held_ff, "window exceeds held flows")
   `ASSERT_ALWAYS(a_held_le_max, clock, reset, held_ff <= MAX_CNT, "held flows exceed ring depth")
   `ASSERT_IMPLY(a_ratio_window, clock, reset, state_ff == ST_RATIO, win_ff == tgt_ff && win_ff <= period_clamp, "window not settled before ratio")
   `ASSERT_IMPLY(a_div_idle_start, clock, reset, div_start, !div_stat.busy, "divider started while busy")

endmodule

`default_nettype wire
